// ===== hw/rtl/rcdtm_pkg.sv =====
`timescale 1ns / 1ps

package rcdtm_pkg;

    // field widths
    localparam int RAW_W     = 11;
    localparam int DRIVE_W   = 10;
    localparam int DZ_W      = 10;
    localparam int FRAC_BITS = 6;
    localparam int SMOOTH_W  = DRIVE_W + FRAC_BITS;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // nominal raw stick span
    localparam logic [RAW_W-1:0] RAW_LO = 11'd172;
    localparam logic [RAW_W-1:0] RAW_HI = 11'd1811;
    localparam longint RAW_SPAN = 1639;

    // scaled drive limits
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 10'd1023;
    localparam logic [DRIVE_W-1:0] DRIVE_MID = 10'd512;
    localparam logic [DZ_W-1:0]    DZ_RESET  = 10'd60;

    // reciprocal multiply: floor(d * k / span) == (d * ceil(k * 2^s / span)) >> s
    // exact for d < span because d * rounding error stays below 2^s
    localparam int RECIP_SHIFT = 22;
    localparam int MULT_W      = 23;
    localparam int PROD_W      = RAW_W + MULT_W;
    localparam longint FWD_MULT_L =
        (longint'(1023) * (longint'(1) << RECIP_SHIFT) + RAW_SPAN - 1) / RAW_SPAN;
    localparam longint TURN_MULT_L =
        (longint'(2046) * (longint'(1) << RECIP_SHIFT) + RAW_SPAN - 1) / RAW_SPAN;
    localparam logic [MULT_W-1:0] FWD_MULT  = FWD_MULT_L[MULT_W-1:0];
    localparam logic [MULT_W-1:0] TURN_MULT = TURN_MULT_L[MULT_W-1:0];

    // smoother reset values in u10.FRAC_BITS
    localparam logic [SMOOTH_W-1:0] SMOOTH_ZERO = '0;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MID  = {DRIVE_MID, {FRAC_BITS{1'b0}}};

    // half-weight first order smoother with truncation
    function automatic logic [SMOOTH_W-1:0] smooth_step(
        input logic [SMOOTH_W-1:0] s,
        input logic [DRIVE_W-1:0]  x
    );
        logic [SMOOTH_W:0] sum;
        sum = {1'b0, x, {FRAC_BITS{1'b0}}} + {1'b0, s};
        return sum[SMOOTH_W:1];
    endfunction

endpackage

// ===== hw/rtl/rc_differential_thrust_mixer.sv =====
`timescale 1ns / 1ps
// a frame accepted on s_axis passes stage a, stage b and stage c, whose smoother registers drive m_axis
// throughput: one frame per cycle while m_axis is not stalled, set by the three-register pipeline with a common stall
// the pipeline stalls only when m_axis holds a result that is not taken
// reset (synchronous, active low): pipeline empty, deadzone 60, lift smoother 0,
// left and right smoothers at midpoint 512

module rc_differential_thrust_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // deadzone write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rcdtm_pkg::DZ_W-1:0]     i_cfg_data,
    // radio frame input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [10:0] aileron_raw, [21:11] elevator_raw, [32:22] throttle_raw, [39:33] zero
    input  logic [rcdtm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // drive output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [9:0] inflate_drive, [19:10] left_drive, [29:20] right_drive, [31:30] zero
    output logic [rcdtm_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rcdtm_pkg::*;

    // pipeline advance: the last stage is free or being emptied this cycle
    logic w_adv;
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // the deadzone register is always writable
    assign o_cfg_ready = 1'b1;

    logic [DZ_W-1:0] r_deadzone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DZ_RESET;
        end else if (i_cfg_valid) begin
            r_deadzone <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // stage a: input register
    // ------------------------------------------------------------------
    logic             r_va;
    logic [RAW_W-1:0] r_ail_raw, r_elv_raw, r_thr_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_adv) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && s_axis_tvalid) begin
            r_ail_raw <= s_axis_tdata[RAW_W-1:0];
            r_elv_raw <= s_axis_tdata[2*RAW_W-1:RAW_W];
            r_thr_raw <= s_axis_tdata[3*RAW_W-1:2*RAW_W];
        end
    end

    // ------------------------------------------------------------------
    // stage b: linear scaling by reciprocal multiply, then clamp
    // below the nominal span the truncated quotient always clamps low,
    // at or above its top it always clamps high, so only the offset
    // inside the span goes through the multiplier
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   w_ail_off, w_elv_off, w_thr_off;
    logic [PROD_W-1:0]  w_ail_prod, w_elv_prod, w_thr_prod;
    logic [RAW_W-1:0]   w_ail_q, w_elv_q, w_thr_q;
    logic signed [RAW_W:0] w_turn_wide;
    logic signed [RAW_W-1:0] n_turn;
    logic [DRIVE_W-1:0] n_fwd, n_lift;

    assign w_ail_off = r_ail_raw - RAW_LO;
    assign w_elv_off = r_elv_raw - RAW_LO;
    assign w_thr_off = r_thr_raw - RAW_LO;

    assign w_ail_prod = PROD_W'(w_ail_off) * PROD_W'(TURN_MULT);
    assign w_elv_prod = PROD_W'(w_elv_off) * PROD_W'(FWD_MULT);
    assign w_thr_prod = PROD_W'(w_thr_off) * PROD_W'(FWD_MULT);

    assign w_ail_q = w_ail_prod[RECIP_SHIFT +: RAW_W];
    assign w_elv_q = w_elv_prod[RECIP_SHIFT +: RAW_W];
    assign w_thr_q = w_thr_prod[RECIP_SHIFT +: RAW_W];

    // turn spans -1023..1023: quotient over 0..2046 minus 1023
    assign w_turn_wide = $signed({1'b0, w_ail_q}) - $signed({2'b00, DRIVE_MAX});

    always_comb begin
        if (r_ail_raw < RAW_LO) begin
            n_turn = -$signed({1'b0, DRIVE_MAX});
        end else if (r_ail_raw >= RAW_HI) begin
            n_turn = $signed({1'b0, DRIVE_MAX});
        end else begin
            n_turn = w_turn_wide[RAW_W-1:0];
        end

        if (r_elv_raw < RAW_LO) begin
            n_fwd = '0;
        end else if (r_elv_raw >= RAW_HI) begin
            n_fwd = DRIVE_MAX;
        end else begin
            n_fwd = w_elv_q[DRIVE_W-1:0];
        end

        if (r_thr_raw < RAW_LO) begin
            n_lift = '0;
        end else if (r_thr_raw >= RAW_HI) begin
            n_lift = DRIVE_MAX;
        end else begin
            n_lift = w_thr_q[DRIVE_W-1:0];
        end
    end

    logic                    r_vb;
    logic signed [RAW_W-1:0] r_turn;
    logic [DRIVE_W-1:0]      r_fwd, r_lift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_adv) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_va) begin
            r_turn <= n_turn;
            r_fwd  <= n_fwd;
            r_lift <= n_lift;
        end
    end

    // ------------------------------------------------------------------
    // stage c: deadzones, differential mix, smoothers
    // ------------------------------------------------------------------
    logic signed [DZ_W+1:0]    w_dz_s, w_fwd_s, w_turn_s, w_mid_s;
    logic                      w_fwd_keep, w_turn_keep;
    logic [DRIVE_W-1:0]        w_fwd_dz;
    logic signed [RAW_W-1:0]   w_turn_dz;
    logic signed [DRIVE_W+2:0] w_left_sum, w_right_sum;
    logic [DRIVE_W-1:0]        w_left, w_right;

    assign w_dz_s   = $signed({2'b00, r_deadzone});
    assign w_fwd_s  = $signed({2'b00, r_fwd});
    assign w_mid_s  = $signed({2'b00, DRIVE_MID});
    assign w_turn_s = (DZ_W+2)'(r_turn);

    // forward snaps to the midpoint inside the band, turn snaps to zero
    assign w_fwd_keep  = (w_fwd_s <= w_mid_s - w_dz_s) || (w_fwd_s >= w_mid_s + w_dz_s);
    assign w_turn_keep = (w_turn_s <= -w_dz_s) || (w_turn_s >= w_dz_s);

    assign w_fwd_dz  = w_fwd_keep ? r_fwd : DRIVE_MID;
    assign w_turn_dz = w_turn_keep ? r_turn : '0;

    assign w_left_sum  = $signed({3'b000, w_fwd_dz}) + (DRIVE_W+3)'(w_turn_dz);
    assign w_right_sum = $signed({3'b000, w_fwd_dz}) - (DRIVE_W+3)'(w_turn_dz);

    always_comb begin
        if (w_left_sum < 0) begin
            w_left = '0;
        end else if (w_left_sum > $signed({3'b000, DRIVE_MAX})) begin
            w_left = DRIVE_MAX;
        end else begin
            w_left = w_left_sum[DRIVE_W-1:0];
        end

        if (w_right_sum < 0) begin
            w_right = '0;
        end else if (w_right_sum > $signed({3'b000, DRIVE_MAX})) begin
            w_right = DRIVE_MAX;
        end else begin
            w_right = w_right_sum[DRIVE_W-1:0];
        end
    end

    // smoother state doubles as the output register
    logic                r_vc;
    logic [SMOOTH_W-1:0] r_inflate_smooth, r_left_smooth, r_right_smooth;
    logic [SMOOTH_W-1:0] n_inflate_smooth, n_left_smooth, n_right_smooth;

    assign n_inflate_smooth = smooth_step(r_inflate_smooth, r_lift);
    assign n_left_smooth    = smooth_step(r_left_smooth, w_left);
    assign n_right_smooth   = smooth_step(r_right_smooth, w_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc             <= 1'b0;
            r_inflate_smooth <= SMOOTH_ZERO;
            r_left_smooth    <= SMOOTH_MID;
            r_right_smooth   <= SMOOTH_MID;
        end else if (w_adv) begin
            r_vc <= r_vb;
            if (r_vb) begin
                r_inflate_smooth <= n_inflate_smooth;
                r_left_smooth    <= n_left_smooth;
                r_right_smooth   <= n_right_smooth;
            end
        end
    end

    // drives are the integer parts of the smoother state
    assign m_axis_tvalid = r_vc;
    assign m_axis_tdata  = {
        (M_TDATA_W - 3*DRIVE_W)'(0),
        r_right_smooth[SMOOTH_W-1:FRAC_BITS],
        r_left_smooth[SMOOTH_W-1:FRAC_BITS],
        r_inflate_smooth[SMOOTH_W-1:FRAC_BITS]
    };

endmodule

// ===== verif/tb_rc_differential_thrust_mixer.sv =====
`timescale 1ns / 1ps

module tb_rc_differential_thrust_mixer;

    import rcdtm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_FRAMES   = 160;
    localparam int NUM_PHASES     = 8;
    localparam int NUM_DIRECTED   = 18;

    typedef struct {
        logic [DRIVE_W-1:0] inflate_drive;
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
    } t_drive_set;

    // keeps its own copy of the smoothers and the deadzone, queues the drives due
    class t_thrust_mix_scoreboard;
        logic [DZ_W-1:0]     deadzone;
        logic [SMOOTH_W-1:0] lift_acc;
        logic [SMOOTH_W-1:0] left_acc;
        logic [SMOOTH_W-1:0] right_acc;
        t_drive_set          drives_due[$];
        int                  errors;
        int                  frames_seen;
        int                  drives_checked;

        function new();
            deadzone       = DZ_RESET;
            lift_acc       = '0;
            left_acc       = SMOOTH_W'(longint'(DRIVE_MID) << FRAC_BITS);
            right_acc      = SMOOTH_W'(longint'(DRIVE_MID) << FRAC_BITS);
            errors         = 0;
            frames_seen    = 0;
            drives_checked = 0;
        endfunction

        function void set_deadzone(logic [DZ_W-1:0] value);
            deadzone = value;
        endfunction

        function int pending();
            return drives_due.size();
        endfunction

        // linear stick scaling, quotient truncated toward zero, then clamped
        function longint scale_stick(logic [RAW_W-1:0] raw, longint lo, longint hi);
            longint num;
            longint val;
            num = (longint'(raw) - longint'(RAW_LO)) * (hi - lo);
            val = num / (longint'(RAW_HI) - longint'(RAW_LO)) + lo;
            if (val < lo) val = lo;
            if (val > hi) val = hi;
            return val;
        endfunction

        function longint clamp_drive(longint v);
            if (v < 0) return 0;
            if (v > longint'(DRIVE_MAX)) return longint'(DRIVE_MAX);
            return v;
        endfunction

        function logic [SMOOTH_W-1:0] halve_toward(logic [SMOOTH_W-1:0] acc, longint x);
            return SMOOTH_W'(((x << FRAC_BITS) + longint'(acc)) >> 1);
        endfunction

        function void note_frame(logic [RAW_W-1:0] aileron, logic [RAW_W-1:0] elevator,
                                 logic [RAW_W-1:0] throttle);
            longint     dz;
            longint     mid;
            longint     turn;
            longint     fwd;
            longint     lift;
            t_drive_set due;
            dz   = longint'(deadzone);
            mid  = longint'(DRIVE_MID);
            turn = scale_stick(aileron, -longint'(DRIVE_MAX), longint'(DRIVE_MAX));
            fwd  = scale_stick(elevator, 0, longint'(DRIVE_MAX));
            lift = scale_stick(throttle, 0, longint'(DRIVE_MAX));
            if (!(fwd <= mid - dz || fwd >= mid + dz)) fwd = mid;
            if (!(turn <= -dz || turn >= dz)) turn = 0;
            lift_acc  = halve_toward(lift_acc, lift);
            left_acc  = halve_toward(left_acc, clamp_drive(fwd + turn));
            right_acc = halve_toward(right_acc, clamp_drive(fwd - turn));
            due.inflate_drive = lift_acc[SMOOTH_W-1:FRAC_BITS];
            due.left_drive    = left_acc[SMOOTH_W-1:FRAC_BITS];
            due.right_drive   = right_acc[SMOOTH_W-1:FRAC_BITS];
            drives_due.push_back(due);
            frames_seen++;
        endfunction

        function void check_drives(logic [M_TDATA_W-1:0] word);
            t_drive_set due;
            t_drive_set got;
            if (drives_due.size() == 0) begin
                $error("drive result 0x%0h with nothing outstanding", word);
                errors++;
                return;
            end
            due = drives_due.pop_front();
            got.inflate_drive = word[DRIVE_W-1:0];
            got.left_drive    = word[2*DRIVE_W-1:DRIVE_W];
            got.right_drive   = word[3*DRIVE_W-1:2*DRIVE_W];
            drives_checked++;
            if (got.inflate_drive !== due.inflate_drive) begin
                $error("inflate_drive: expected %0d, got %0d",
                       due.inflate_drive, got.inflate_drive);
                errors++;
            end
            if (got.left_drive !== due.left_drive) begin
                $error("left_drive: expected %0d, got %0d", due.left_drive, got.left_drive);
                errors++;
            end
            if (got.right_drive !== due.right_drive) begin
                $error("right_drive: expected %0d, got %0d", due.right_drive, got.right_drive);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [DZ_W-1:0]        i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    t_thrust_mix_scoreboard sb = new();

    bit sender_steady     = 1'b0;
    bit receiver_steady   = 1'b0;
    bit long_hold_pending = 1'b0;
    int long_holds        = 0;
    int deadzone_writes   = 0;

    logic [RAW_W-1:0] corner_raw [8] = '{11'd0, 11'd171, 11'd172, 11'd173,
                                         11'd1810, 11'd1811, 11'd1812, 11'd2047};

    // aileron, elevator, throttle: range ends, midpoint, deadzone edges at 60, mix clamps
    logic [RAW_W-1:0] directed_raw [NUM_DIRECTED][3] = '{
        '{11'd0,    11'd0,    11'd0},
        '{11'd2047, 11'd2047, 11'd2047},
        '{11'd172,  11'd172,  11'd172},
        '{11'd1811, 11'd1811, 11'd1811},
        '{11'd171,  11'd1812, 11'd171},
        '{11'd1812, 11'd171,  11'd1812},
        '{11'd991,  11'd991,  11'd991},
        '{11'd992,  11'd992,  11'd992},
        '{11'd1040, 11'd897,  11'd1000},
        '{11'd1039, 11'd898,  11'd1000},
        '{11'd944,  11'd1089, 11'd500},
        '{11'd945,  11'd1088, 11'd500},
        '{11'd1811, 11'd1811, 11'd300},
        '{11'd172,  11'd172,  11'd300},
        '{11'd1811, 11'd172,  11'd1200},
        '{11'd172,  11'd1811, 11'd1200},
        '{11'd1365, 11'd1365, 11'd1365},
        '{11'd682,  11'd682,  11'd682}
    };

    rc_differential_thrust_mixer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // transactions are sampled at the edge, before any update of that edge lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_deadzone(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_frame(s_axis_tdata[RAW_W-1:0], s_axis_tdata[2*RAW_W-1:RAW_W],
                              s_axis_tdata[3*RAW_W-1:2*RAW_W]);
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_drives(m_axis_tdata);
        end
    end

    // drive consumer: short stalls mostly, a few long ones, one forced long hold-off
    initial begin
        int hold_left;
        int r;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left         = LONG_HOLD;
                long_holds++;
            end else if (hold_left == 0 && !receiver_steady) begin
                r = $urandom_range(0, 99);
                if (r >= 97) hold_left = $urandom_range(10, 40);
                else if (r >= 75) hold_left = $urandom_range(1, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ends the run when no transaction has happened for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired with %0d drive results outstanding", sb.pending());
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (sender_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw(bit centered);
        int r;
        r = $urandom_range(0, 99);
        if (centered && r < 45) return RAW_W'($urandom_range(820, 1160));
        if (r < 60) return RAW_W'($urandom_range(172, 1811));
        if (r < 85) return RAW_W'($urandom_range(0, 2047));
        return corner_raw[$urandom_range(0, 7)];
    endfunction

    task automatic send_frame(input logic [RAW_W-1:0] aileron,
                              input logic [RAW_W-1:0] elevator,
                              input logic [RAW_W-1:0] throttle);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-3*RAW_W){1'b0}}, throttle, elevator, aileron};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop offering frames and wait for every outstanding drive result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_deadzone(input logic [DZ_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        deadzone_writes++;
    endtask

    initial begin
        int dz_plan [NUM_PHASES];
        bit centered;
        dz_plan = '{0, 1023, 60, 1, 512, -1, -1, -1};

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the deadzone left by reset
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_frame(directed_raw[i][0], directed_raw[i][1], directed_raw[i][2]);
            pause_sender(pick_gap());
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            if (dz_plan[p] < 0) write_deadzone(DZ_W'($urandom_range(0, 1023)));
            else write_deadzone(DZ_W'(dz_plan[p]));
            if (p == 2) begin
                // back-pressure: consumer holds off while frames keep coming
                long_hold_pending = 1'b1;
                sender_steady     = 1'b1;
            end
            if (p == 4) begin
                sender_steady   = 1'b1;
                receiver_steady = 1'b1;
            end
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                if (p == 2 && i == 100) sender_steady = 1'b0;
                centered = ($urandom_range(0, 1) == 1);
                send_frame(pick_raw(centered), pick_raw(centered), pick_raw(1'b0));
                pause_sender(pick_gap());
                if ($urandom_range(0, 199) == 0) drain_results();
            end
            sender_steady   = 1'b0;
            receiver_steady = 1'b0;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d frames, %0d drive results checked, %0d deadzone settings",
                 sb.frames_seen, sb.drives_checked, deadzone_writes);
        $display("run: %0d forced consumer hold-offs, %0d mismatches",
                 long_holds, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
